FILE: sv/nevq_pkg.sv
// ----------------------------------------------------------------------------
// nevq_pkg: shared types and constants for the field-norm quality tracker
// Register indexes, reset values and the item passed between front and back.
// ----------------------------------------------------------------------------
package nevq_pkg;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_NORM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd3;
	localparam logic [15:0] WEIGHT_RST = 16'd655;
	localparam logic [15:0] MIN_NORM_RST = 16'd1;
	localparam logic [15:0] MIN_COUNT_RST = 16'd100;
	localparam logic [16:0] QUALITY_ONE = 17'd65536;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [31:0] sample;
		logic clear;
		logic take;
	} item_t;
endpackage

FILE: sv/norm_ema_variance_quality.sv
// ----------------------------------------------------------------------------
// norm_ema_variance_quality: field-norm EMA mean/variance quality tracker
// Steps from input accept to result for an updating sample:
// 1 hand-off, 4 multiply steps, 1 setup, 32 square-root and 82 divide steps,
// 1 result load; a clear, ignored or first sample skips the multiply steps.
// One item at a time: a new item starts only once the last result is loaded,
// which waits while a result is held unread. Two-entry input queue.
// Reset clears the tracker, the queue and restores register defaults.
// ----------------------------------------------------------------------------
module norm_ema_variance_quality import nevq_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [31:0] norm_sample,
	input  logic clear,
	output logic empty,
	input  logic pop,
	output logic [16:0] quality,
	output logic quality_valid,
	output logic [15:0] sample_count,
	output logic sample_taken,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic track_q;
	logic [15:0] weight_q, min_norm_q, min_count_q;
	logic q_valid, q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= 1'b1;
			weight_q <= WEIGHT_RST;
			min_norm_q <= MIN_NORM_RST;
			min_count_q <= MIN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRACK: track_q <= cfg_data[0];
				REG_WEIGHT: weight_q <= cfg_data;
				REG_MIN_NORM: min_norm_q <= cfg_data;
				REG_MIN_COUNT: min_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nevq_front u_front (
		.clk, .arst_n, .push, .full, .norm_sample, .clear,
		.track_en(track_q), .min_norm(min_norm_q),
		.q_valid, .q_item, .q_pop
	);

	nevq_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_pop,
		.weight(weight_q), .min_norm(min_norm_q), .min_count(min_count_q),
		.empty, .pop, .quality, .quality_valid, .sample_count, .sample_taken
	);
endmodule

FILE: sv/nevq_front.sv
// ----------------------------------------------------------------------------
// nevq_front: input queue side
// Accept requests, classify them as clear, taken sample or ignored, and queue.
// ----------------------------------------------------------------------------
module nevq_front import nevq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [31:0] norm_sample,
	input  logic clear,
	input  logic track_en,
	input  logic [15:0] min_norm,
	output logic q_valid,
	output item_t q_item,
	input  logic q_pop
);
	item_t mem_q [QDEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;
	item_t it;

	assign full = (cnt_q == 2'(QDEPTH));
	assign do_push = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign do_pop = q_pop && q_valid;
	assign q_item = mem_q[rd_q];

	always_comb begin
		it.sample = norm_sample;
		it.clear = clear;
		it.take = !clear && track_en && (norm_sample >= {16'd0, min_norm});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= it;
	end
endmodule

FILE: sv/nevq_back.sv
// ----------------------------------------------------------------------------
// nevq_back: tracker update and quality figure
// Update mean and variance with a shared 32x16 multiplier, then run a serial
// square root and a serial divide, and hold the result for the reader.
// ----------------------------------------------------------------------------
module nevq_back import nevq_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  item_t q_item,
	output logic q_pop,
	input  logic [15:0] weight,
	input  logic [15:0] min_norm,
	input  logic [15:0] min_count,
	output logic empty,
	input  logic pop,
	output logic [16:0] quality,
	output logic quality_valid,
	output logic [15:0] sample_count,
	output logic sample_taken
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_M0 = 4'd1, ST_M1 = 4'd2, ST_V0 = 4'd3,
		ST_V1 = 4'd4, ST_V2 = 4'd5, ST_UPD = 4'd6, ST_SQRT = 4'd7, ST_DIV = 4'd8,
		ST_OUT = 4'd9;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic [3:0] st_q;
	logic [47:0] mean_q;
	logic [63:0] var_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic take_q;
	logic neg_q, vneg_q;
	logic [47:0] mag_q;
	logic [63:0] vmag_q;
	logic [63:0] acc_q;
	logic [31:0] d_q;
	logic [63:0] sq_q;
	logic [63:0] rad_q, root_q, bit_q;
	logic [80:0] num_q;
	logic [48:0] rem_q;
	logic [6:0] it_q;
	logic valid_q;
	logic out_v_q;
	logic [16:0] qual_q;
	logic res_valid_q;
	logic [15:0] res_cnt_q;
	logic res_taken_q;

	logic [31:0] mul_a;
	logic [47:0] mul_p;
	logic [63:0] sq_p;
	logic [47:0] s48;
	logic [63:0] sd;
	logic [49:0] rtry;
	logic [63:0] rsum;
	logic [15:0] cnt_sat;

	assign s48 = {q_item.sample, 16'd0};
	assign mul_p = 48'(mul_a) * 48'(weight);
	assign sq_p = 64'(d_q) * 64'(d_q);
	assign rsum = root_q + bit_q;
	assign sd = root_q;
	assign rtry = {rem_q, num_q[80]} - {2'b0, mean_q};

	always_comb begin
		unique case (st_q)
			ST_M0: mul_a = {16'd0, mag_q[47:32]};
			ST_M1: mul_a = mag_q[31:0];
			ST_V1: mul_a = vmag_q[63:32];
			ST_V2: mul_a = vmag_q[31:0];
			default: mul_a = '0;
		endcase
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign empty = !out_v_q;
	assign quality = qual_q;
	assign quality_valid = res_valid_q;
	assign cnt_sat = (COUNT_BITS > 16) ?
		((cnt_q > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(cnt_q)) : 16'(cnt_q);
	assign sample_count = res_cnt_q;
	assign sample_taken = res_taken_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mean_q <= '0;
			var_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) begin
					take_q <= q_item.take;
					if (q_item.clear) begin
						mean_q <= '0;
						var_q <= '0;
						cnt_q <= '0;
						st_q <= ST_UPD;
					end else if (!q_item.take) begin
						st_q <= ST_UPD;
					end else if (cnt_q == '0) begin
						mean_q <= s48;
						var_q <= '0;
						cnt_q <= cnt_q + 1'b1;
						st_q <= ST_UPD;
					end else begin
						neg_q <= s48 < mean_q;
						mag_q <= (s48 < mean_q) ? mean_q - s48 : s48 - mean_q;
						d_q <= (s48 < mean_q) ? 32'((mean_q - s48) >> 16)
							: 32'((s48 - mean_q) >> 16);
						if (cnt_q != CMAX) cnt_q <= cnt_q + 1'b1;
						st_q <= ST_M0;
					end
				end
				ST_M0: begin
					acc_q <= {mul_p[47:0], 16'd0};
					sq_q <= sq_p;
					st_q <= ST_M1;
				end
				ST_M1: begin
					mean_q <= neg_q ? mean_q - 48'(acc_q + ((64'(mul_p) + 64'd32768) >> 16))
						: mean_q + 48'(acc_q + ((64'(mul_p) + 64'd32768) >> 16));
					vneg_q <= sq_q < var_q;
					vmag_q <= (sq_q < var_q) ? var_q - sq_q : sq_q - var_q;
					st_q <= ST_V1;
				end
				ST_V1: begin
					acc_q <= {mul_p[47:0], 16'd0};
					st_q <= ST_V2;
				end
				ST_V2: begin
					var_q <= vneg_q ? var_q - (acc_q + ((64'(mul_p) + 64'd32768) >> 16))
						: var_q + (acc_q + ((64'(mul_p) + 64'd32768) >> 16));
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					valid_q <= (32'(cnt_q) >= 32'(min_count)) && (mean_q != '0)
						&& (mean_q >= {16'd0, min_norm, 16'd0});
					rad_q <= var_q;
					root_q <= '0;
					bit_q <= 64'd1 << 62;
					it_q <= '0;
					st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rad_q >= rsum) begin
						rad_q <= rad_q - rsum;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (it_q == 7'd0) begin
						num_q <= {17'd0, (sd > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sd[31:0], 32'd0};
						rem_q <= '0;
						it_q <= 7'd1;
					end else begin
						if (!rtry[49]) rem_q <= rtry[48:0];
						else rem_q <= {rem_q[47:0], num_q[80]};
						num_q <= {num_q[79:0], !rtry[49]};
						if (it_q == 7'd81) st_q <= ST_OUT;
						else it_q <= it_q + 7'd1;
					end
				end
				ST_OUT: if (!out_v_q) begin
					qual_q <= (!valid_q) ? QUALITY_ONE
						: ((num_q > 81'(QUALITY_ONE)) ? QUALITY_ONE : num_q[16:0]);
					res_valid_q <= valid_q;
					res_cnt_q <= cnt_sat;
					res_taken_q <= take_q;
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/nevq_checker.sv
// ----------------------------------------------------------------------------
// nevq_checker: port-level checks for the quality tracker
// Result ranges and queue behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module nevq_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [16:0] quality,
	input logic quality_valid,
	input logic sample_taken,
	input logic [15:0] sample_count
);
	a_qrange: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> quality <= 17'd65536) else $error("quality out of range");
	a_invalid_one: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !quality_valid) |-> quality == 17'd65536) else $error("invalid figure");
	a_taken_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sample_taken) |-> sample_count != 16'd0) else $error("taken but zero count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(quality))) else $error("result dropped");
endmodule

bind norm_ema_variance_quality nevq_checker u_chk (
	.clk, .arst_n, .empty, .pop, .quality, .quality_valid, .sample_taken, .sample_count
);
